### sv/csvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg: shared types and constants of the CSV record tokenizer
// Event codes, character constants and the event bundle that the front end
// hands to the back end through the queue.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int MAX_EV   = 9;
  localparam int EV_IDX_W = $clog2(MAX_EV + 1);

  localparam logic [2:0] EV_CHAR      = 3'd0;
  localparam logic [2:0] EV_FIELD_END = 3'd1;
  localparam logic [2:0] EV_REC_END   = 3'd2;
  localparam logic [2:0] EV_DONE      = 3'd3;
  localparam logic [2:0] EV_ERR_QUOTE = 3'd4;
  localparam logic [2:0] EV_ERR_OPEN  = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] BOM_0    = 8'hEF;
  localparam logic [7:0] BOM_1    = 8'hBB;
  localparam logic [7:0] BOM_2    = 8'hBF;

  localparam logic [1:0] BOM_PAST = 2'd3;

  // All events caused by one input byte, in order, packed from slot 0.
  typedef struct packed {
    logic [MAX_EV-1:0][2:0] kind;
    logic [MAX_EV-1:0][7:0] chr;
    logic [EV_IDX_W-1:0]    count;
  } bundle_t;

  function automatic logic [7:0] mark_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = BOM_0;
      2'd1:    b = BOM_1;
      2'd2:    b = BOM_2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/csv_record_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer: streaming CSV tokenizer
// Turns upload bytes into field character, field end, record end, done and
// error events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one raw byte per request, with
//   upload_end set on the final byte of an upload.
//   Output channel (out_valid/out_ready): one event per request; run_last
//   marks the last event caused by an input byte. A byte may cause no event.
//   Path: a byte's events are written into the queue, then loaded one at a
//   time into the output register that presents them to the receiver.
//   Throughput: one byte per cycle while each byte causes at most one event
//   and the receiver is ready; a byte causing several events occupies the
//   serialiser until all of them are given, and the two-entry queue lets
//   input continue while such a burst drains.
//   Reset clears the tokenizer state, the queue and the output stage; the
//   block then expects the start of a new upload.
//   When the receiver stalls, the output holds its event, the queue fills
//   and in_ready falls once both queue entries are taken.
// ----------------------------------------------------------------------------
module csv_record_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       upload_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] char_value,
  output logic       run_last
);

  csvt_pkg::bundle_t wbundle, head;
  logic push, pop, q_full, q_nonempty;

  csvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .upload_end (upload_end),
    .q_full     (q_full),
    .push       (push),
    .bundle     (wbundle)
  );

  csvt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wbundle),
    .pop      (pop),
    .rdata    (head),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .char_value (char_value),
    .run_last   (run_last)
  );

endmodule

### sv/csvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_front: byte classifier and tokenizer state
// Takes one byte a cycle while the queue is not full, updates the tokenizer
// state and builds the ordered bundle of events that the byte causes.
// ----------------------------------------------------------------------------
module csvt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 upload_end,
  input  logic                 q_full,
  output logic                 push,
  output csvt_pkg::bundle_t    bundle
);

  localparam logic [1:0] Q_OUT  = 2'd0;
  localparam logic [1:0] Q_IN   = 2'd1;
  localparam logic [1:0] Q_PEND = 2'd2;
  localparam int NCAND = 11;

  logic [1:0] bom_phase, bom_phase_next;
  logic [1:0] quote_phase, quote_phase_next;
  logic       field_has_chars, field_has_chars_next;
  logic       record_has_fields, record_has_fields_next;
  logic       cr_held, cr_held_next;
  logic       error_seen, error_seen_next;

  logic [NCAND-1:0]      cand_en;
  logic [NCAND-1:0][2:0] cand_kind;
  logic [NCAND-1:0][7:0] cand_char;
  logic [1:0]            flush;
  logic                  take, unq, put;
  logic [7:0]            pc;
  logic [csvt_pkg::EV_IDX_W-1:0] n;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && (bundle.count != '0);

  // Candidate slots in emission order: held mark bytes, released carriage
  // return, field character, field end, record end, stray quote, then the
  // end-of-upload events.
  always_comb begin
    bom_phase_next         = bom_phase;
    quote_phase_next       = quote_phase;
    field_has_chars_next   = field_has_chars;
    record_has_fields_next = record_has_fields;
    cr_held_next           = cr_held;
    error_seen_next        = error_seen;
    cand_en   = '0;
    cand_kind = '0;
    cand_char = '0;
    cand_kind[0]  = csvt_pkg::EV_CHAR;       cand_char[0] = csvt_pkg::BOM_0;
    cand_kind[1]  = csvt_pkg::EV_CHAR;       cand_char[1] = csvt_pkg::BOM_1;
    cand_kind[2]  = csvt_pkg::EV_CHAR;       cand_char[2] = csvt_pkg::CH_CR;
    cand_kind[3]  = csvt_pkg::EV_CHAR;
    cand_kind[4]  = csvt_pkg::EV_FIELD_END;
    cand_kind[5]  = csvt_pkg::EV_REC_END;
    cand_kind[6]  = csvt_pkg::EV_ERR_QUOTE;
    cand_kind[7]  = csvt_pkg::EV_ERR_OPEN;
    cand_kind[8]  = csvt_pkg::EV_FIELD_END;
    cand_kind[9]  = csvt_pkg::EV_REC_END;
    cand_kind[10] = csvt_pkg::EV_DONE;
    flush = 2'd0;
    take  = 1'b0;
    unq   = 1'b0;
    put   = 1'b0;
    pc    = data_byte;

    if (!error_seen) begin
      if (bom_phase != csvt_pkg::BOM_PAST) begin
        if (data_byte == csvt_pkg::mark_byte(bom_phase)) begin
          bom_phase_next = bom_phase + 2'd1;
          if (upload_end && bom_phase_next != csvt_pkg::BOM_PAST) begin
            flush          = bom_phase_next;
            bom_phase_next = csvt_pkg::BOM_PAST;
          end
        end else begin
          flush          = bom_phase;
          bom_phase_next = csvt_pkg::BOM_PAST;
          take           = 1'b1;
        end
      end else begin
        take = 1'b1;
      end
    end

    cand_en[0] = (flush != 2'd0);
    cand_en[1] = (flush == 2'd2);
    if (flush != 2'd0) field_has_chars_next = 1'b1;

    if (take) begin
      case (quote_phase)
        Q_PEND: begin
          if (data_byte == csvt_pkg::CH_QUOTE) begin
            put              = 1'b1;
            quote_phase_next = Q_IN;
          end else begin
            quote_phase_next = Q_OUT;
            unq              = 1'b1;
          end
        end
        Q_IN: begin
          if (data_byte == csvt_pkg::CH_QUOTE) quote_phase_next = Q_PEND;
          else put = 1'b1;
        end
        default: begin
          quote_phase_next = Q_OUT;
          unq              = 1'b1;
        end
      endcase

      if (unq) begin
        if (data_byte == csvt_pkg::CH_QUOTE) begin
          if (field_has_chars_next) begin
            cand_en[6]      = 1'b1;
            error_seen_next = 1'b1;
          end else begin
            quote_phase_next = Q_IN;
          end
        end else if (data_byte == csvt_pkg::CH_COMMA) begin
          cand_en[2]             = cr_held;
          cr_held_next           = 1'b0;
          cand_en[4]             = 1'b1;
          field_has_chars_next   = 1'b0;
          record_has_fields_next = 1'b1;
        end else if (data_byte == csvt_pkg::CH_LF) begin
          cr_held_next           = 1'b0;
          cand_en[4]             = 1'b1;
          cand_en[5]             = 1'b1;
          field_has_chars_next   = 1'b0;
          record_has_fields_next = 1'b0;
        end else begin
          put = 1'b1;
        end
      end

      if (put) begin
        cand_en[2]           = cr_held;
        cand_char[3]         = pc;
        cand_en[3]           = (pc != csvt_pkg::CH_CR);
        cr_held_next         = (pc == csvt_pkg::CH_CR);
        field_has_chars_next = 1'b1;
      end
    end

    if (upload_end) begin
      if (!error_seen_next) begin
        if (quote_phase_next == Q_IN) begin
          cand_en[7] = 1'b1;
        end else begin
          cand_en[8]  = field_has_chars_next || record_has_fields_next;
          cand_en[9]  = field_has_chars_next || record_has_fields_next;
          cand_en[10] = 1'b1;
        end
      end
      bom_phase_next         = 2'd0;
      quote_phase_next       = Q_OUT;
      field_has_chars_next   = 1'b0;
      record_has_fields_next = 1'b0;
      cr_held_next           = 1'b0;
      error_seen_next        = 1'b0;
    end
  end

  // Pack the enabled slots towards slot 0.
  always_comb begin
    bundle.kind = '0;
    bundle.chr  = '0;
    n = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && n < csvt_pkg::EV_IDX_W'(csvt_pkg::MAX_EV)) begin
        bundle.kind[n] = cand_kind[i];
        bundle.chr[n]  = cand_char[i];
        n = n + 1'b1;
      end
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bom_phase         <= 2'd0;
      quote_phase       <= Q_OUT;
      field_has_chars   <= 1'b0;
      record_has_fields <= 1'b0;
      cr_held           <= 1'b0;
      error_seen        <= 1'b0;
    end else if (in_valid && in_ready) begin
      bom_phase         <= bom_phase_next;
      quote_phase       <= quote_phase_next;
      field_has_chars   <= field_has_chars_next;
      record_has_fields <= record_has_fields_next;
      cr_held           <= cr_held_next;
      error_seen        <= error_seen_next;
    end
  end

endmodule

### sv/csvt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_queue: two-entry bundle queue
// Decouples the byte classifier from the event serialiser.
// ----------------------------------------------------------------------------
module csvt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvt_pkg::bundle_t wdata,
  input  logic              pop,
  output csvt_pkg::bundle_t rdata,
  output logic              full,
  output logic              nonempty
);

  csvt_pkg::bundle_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

### sv/csvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_back: event serialiser
// Walks the bundle at the head of the queue and gives one event a cycle
// through a registered output stage while the receiver is ready.
// ----------------------------------------------------------------------------
module csvt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  csvt_pkg::bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_kind,
  output logic [7:0]        char_value,
  output logic              run_last
);

  logic [csvt_pkg::EV_IDX_W-1:0] pos;
  logic load, at_end;

  assign load   = q_nonempty && (!out_valid || out_ready);
  assign at_end = (pos == head.count - 1'b1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= at_end ? '0 : pos + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind <= head.kind[pos];
      char_value <= head.chr[pos];
      run_last   <= at_end;
    end
  end

endmodule
